### src/tak_pkg.sv
// shared types, codes and constants of the telnet key input decoder
package tak_pkg;

  // parser phase codes
  localparam logic [3:0] PH_IDLE         = 4'd0;
  localparam logic [3:0] PH_ESC          = 4'd1;
  localparam logic [3:0] PH_ESC_BR       = 4'd2;
  localparam logic [3:0] PH_IAC          = 4'd3;
  localparam logic [3:0] PH_NEG          = 4'd4;
  localparam logic [3:0] PH_SB           = 4'd5;
  localparam logic [3:0] PH_NAWS_DATA    = 4'd6;
  localparam logic [3:0] PH_NAWS_FF      = 4'd7;
  localparam logic [3:0] PH_NAWS_END     = 4'd8;
  localparam logic [3:0] PH_NAWS_END_IAC = 4'd9;
  localparam logic [3:0] PH_SKIP         = 4'd10;
  localparam logic [3:0] PH_SKIP_IAC     = 4'd11;

  // received byte values
  localparam logic [7:0] B_ESC    = 8'h1B;
  localparam logic [7:0] B_CR     = 8'h0D;
  localparam logic [7:0] B_SPACE  = 8'h20;
  localparam logic [7:0] B_BRACK  = 8'h5B;
  localparam logic [7:0] B_UP     = 8'h41;
  localparam logic [7:0] B_DOWN   = 8'h42;
  localparam logic [7:0] B_RIGHT  = 8'h43;
  localparam logic [7:0] B_LEFT   = 8'h44;
  localparam logic [7:0] B_IAC    = 8'hFF;
  localparam logic [7:0] B_WILL   = 8'd251;
  localparam logic [7:0] B_WONT   = 8'd252;
  localparam logic [7:0] B_DO     = 8'd253;
  localparam logic [7:0] B_DONT   = 8'd254;
  localparam logic [7:0] B_SB     = 8'd250;
  localparam logic [7:0] B_SE     = 8'd240;
  localparam logic [7:0] OPT_NAWS = 8'd31;

  // other_keys bit positions
  localparam int K_SPACE = 0;
  localparam int K_ENTER = 1;
  localparam int K_ESC   = 2;
  localparam int K_UP    = 3;
  localparam int K_DOWN  = 4;
  localparam int K_LEFT  = 5;
  localparam int K_RIGHT = 6;

  // configuration register indexes and reset values
  localparam logic [1:0] REG_MIN_COLS = 2'd0;
  localparam logic [1:0] REG_MAX_COLS = 2'd1;
  localparam logic [1:0] REG_MIN_ROWS = 2'd2;
  localparam logic [1:0] REG_MAX_ROWS = 2'd3;
  localparam logic [15:0] RST_MIN_COLS = 16'd80;
  localparam logic [15:0] RST_MAX_COLS = 16'd200;
  localparam logic [15:0] RST_MIN_ROWS = 16'd24;
  localparam logic [15:0] RST_MAX_ROWS = 16'd200;

  // number of size bytes in a window size report
  localparam logic [2:0] NAWS_BYTES = 3'd4;

  typedef struct packed {
    logic        command;
    logic [7:0]  data_byte;
    logic        last_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [25:0] letter_keys;
    logic [9:0]  digit_keys;
    logic [6:0]  other_keys;
    logic        window_size_enabled;
    logic        resize_valid;
    logic [15:0] width_cols;
    logic [15:0] height_rows;
  } out_item_t;

endpackage

### src/tak_intf.sv
// valid/ready channel interfaces for input bytes and decoded results
interface tak_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  data_byte;
  logic        last_of_buffer;

  modport source (output valid, command, data_byte, last_of_buffer, input ready);
  modport sink (input valid, command, data_byte, last_of_buffer, output ready);
endinterface

interface tak_out_if;
  logic        valid;
  logic        ready;
  logic [25:0] letter_keys;
  logic [9:0]  digit_keys;
  logic [6:0]  other_keys;
  logic        window_size_enabled;
  logic        resize_valid;
  logic [15:0] width_cols;
  logic [15:0] height_rows;

  modport source (output valid, letter_keys, digit_keys, other_keys, window_size_enabled,
                  resize_valid, width_cols, height_rows, input ready);
  modport sink (input valid, letter_keys, digit_keys, other_keys, window_size_enabled,
                resize_valid, width_cols, height_rows, output ready);
endinterface

### src/telnet_ansi_key_input_decoder_top.sv
// top level of the telnet key input decoder: parser, sticky flags, clamp, config regs
//
//  channel | direction | handshake              | payload
//  in_ch   | in        | valid/ready            | command, data_byte, last_of_buffer
//  out_ch  | out       | valid/ready            | key flags, naws flag, resize, size
//  cfg_*   | in        | apb write, pready high | min/max cols and rows, 16 bit each
//
// one byte per cycle unless a full, unread output register holds off in_ch: each transfer
// is decoded in the cycle it is taken and the result lands in the output register at that edge
// the output register frees in the same cycle it is taken, so a stalled out_ch
// holds off in_ch only while the register is full and not being read
// synchronous active-low reset clears parser state, flags and config registers
module telnet_ansi_key_input_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  tak_in_if.sink      in_ch,
  tak_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // parser and flag state
  logic [3:0]  phase_r,     phase_nxt;
  logic        neg_will_r,  neg_will_nxt;
  logic [31:0] size_sh_r,   size_sh_nxt;
  logic [2:0]  size_cnt_r,  size_cnt_nxt;
  logic [25:0] letters_r,   letters_nxt;
  logic [9:0]  digits_r,    digits_nxt;
  logic [6:0]  others_r,    others_nxt;
  logic        naws_on_r,   naws_on_nxt;

  // config registers
  logic [15:0] min_cols_r, max_cols_r, min_rows_r, max_rows_r;

  // output register
  logic              out_valid_r;
  tak_pkg::out_item_t out_r, out_nxt;

  logic        in_fire;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;
  logic        resized;
  logic [15:0] cols_raw, rows_raw, cols_cl, rows_cl;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_idx)
      tak_pkg::REG_MIN_COLS: cfg_prdata = {16'd0, min_cols_r};
      tak_pkg::REG_MAX_COLS: cfg_prdata = {16'd0, max_cols_r};
      tak_pkg::REG_MIN_ROWS: cfg_prdata = {16'd0, min_rows_r};
      tak_pkg::REG_MAX_ROWS: cfg_prdata = {16'd0, max_rows_r};
      default:               cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_cols_r <= tak_pkg::RST_MIN_COLS;
      max_cols_r <= tak_pkg::RST_MAX_COLS;
      min_rows_r <= tak_pkg::RST_MIN_ROWS;
      max_rows_r <= tak_pkg::RST_MAX_ROWS;
    end else if (cfg_wr) begin
      case (cfg_idx)
        tak_pkg::REG_MIN_COLS: min_cols_r <= cfg_pwdata[15:0];
        tak_pkg::REG_MAX_COLS: max_cols_r <= cfg_pwdata[15:0];
        tak_pkg::REG_MIN_ROWS: min_rows_r <= cfg_pwdata[15:0];
        tak_pkg::REG_MAX_ROWS: max_rows_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // byte decode: a byte may fall through at most three phases
  // (end of report, then telnet command, then plain data)
  always_comb begin
    logic [7:0] b;
    logic       redo;
    b            = in_ch.data_byte;
    phase_nxt    = phase_r;
    neg_will_nxt = neg_will_r;
    size_sh_nxt  = size_sh_r;
    size_cnt_nxt = size_cnt_r;
    letters_nxt  = letters_r;
    digits_nxt   = digits_r;
    others_nxt   = others_r;
    naws_on_nxt  = naws_on_r;
    resized      = 1'b0;
    redo         = 1'b1;

    if (in_ch.command) begin
      // clear command: only the sticky key flags
      letters_nxt = '0;
      digits_nxt  = '0;
      others_nxt  = '0;
    end else begin
      for (int pass = 0; pass < 3; pass++) begin
        if (redo) begin
          redo = 1'b0;
          case (phase_nxt)
            tak_pkg::PH_ESC: begin
              if (b == tak_pkg::B_BRACK) begin
                phase_nxt = tak_pkg::PH_ESC_BR;
              end else begin
                others_nxt[tak_pkg::K_ESC] = 1'b1;
                phase_nxt = tak_pkg::PH_IDLE;
                redo = 1'b1;
              end
            end
            tak_pkg::PH_ESC_BR: begin
              phase_nxt = tak_pkg::PH_IDLE;
              if (b == tak_pkg::B_UP)         others_nxt[tak_pkg::K_UP]    = 1'b1;
              else if (b == tak_pkg::B_DOWN)  others_nxt[tak_pkg::K_DOWN]  = 1'b1;
              else if (b == tak_pkg::B_RIGHT) others_nxt[tak_pkg::K_RIGHT] = 1'b1;
              else if (b == tak_pkg::B_LEFT)  others_nxt[tak_pkg::K_LEFT]  = 1'b1;
              else begin
                others_nxt[tak_pkg::K_ESC] = 1'b1;
                redo = 1'b1;
              end
            end
            tak_pkg::PH_IAC: begin
              if (b == tak_pkg::B_IAC) begin
                phase_nxt = tak_pkg::PH_IDLE;
              end else if (b inside {tak_pkg::B_WILL, tak_pkg::B_WONT,
                                     tak_pkg::B_DO, tak_pkg::B_DONT}) begin
                neg_will_nxt = (b == tak_pkg::B_WILL);
                phase_nxt = tak_pkg::PH_NEG;
              end else if (b == tak_pkg::B_SB) begin
                phase_nxt = tak_pkg::PH_SB;
              end else begin
                phase_nxt = tak_pkg::PH_IDLE;
                redo = 1'b1;
              end
            end
            tak_pkg::PH_NEG: begin
              if (b == tak_pkg::OPT_NAWS) naws_on_nxt = neg_will_nxt;
              phase_nxt = tak_pkg::PH_IDLE;
            end
            tak_pkg::PH_SB: begin
              if (b == tak_pkg::OPT_NAWS) begin
                size_sh_nxt  = '0;
                size_cnt_nxt = '0;
                phase_nxt    = tak_pkg::PH_NAWS_DATA;
              end else begin
                phase_nxt = tak_pkg::PH_SKIP;
              end
            end
            tak_pkg::PH_NAWS_DATA, tak_pkg::PH_NAWS_FF: begin
              if (phase_nxt == tak_pkg::PH_NAWS_DATA && b == tak_pkg::B_IAC) begin
                phase_nxt = tak_pkg::PH_NAWS_FF;
              end else if (phase_nxt == tak_pkg::PH_NAWS_FF && b != tak_pkg::B_IAC) begin
                // undoubled 0xff: that byte was a telnet command after all
                phase_nxt = tak_pkg::PH_IAC;
                redo = 1'b1;
              end else begin
                size_sh_nxt  = {size_sh_nxt[23:0], b};
                size_cnt_nxt = size_cnt_nxt + 3'd1;
                phase_nxt    = (size_cnt_nxt >= tak_pkg::NAWS_BYTES) ?
                               tak_pkg::PH_NAWS_END : tak_pkg::PH_NAWS_DATA;
              end
            end
            tak_pkg::PH_NAWS_END: begin
              if (b == tak_pkg::B_IAC) begin
                phase_nxt = tak_pkg::PH_NAWS_END_IAC;
              end else begin
                phase_nxt = tak_pkg::PH_IDLE;
                redo = 1'b1;
              end
            end
            tak_pkg::PH_NAWS_END_IAC: begin
              if (b == tak_pkg::B_SE) begin
                phase_nxt = tak_pkg::PH_IDLE;
                resized = 1'b1;
              end else begin
                phase_nxt = tak_pkg::PH_IAC;
                redo = 1'b1;
              end
            end
            tak_pkg::PH_SKIP: begin
              if (b == tak_pkg::B_IAC) phase_nxt = tak_pkg::PH_SKIP_IAC;
            end
            tak_pkg::PH_SKIP_IAC: begin
              phase_nxt = (b == tak_pkg::B_SE) ? tak_pkg::PH_IDLE : tak_pkg::PH_SKIP;
            end
            default: begin
              // plain data byte
              phase_nxt = tak_pkg::PH_IDLE;
              if (b == tak_pkg::B_SPACE) begin
                others_nxt[tak_pkg::K_SPACE] = 1'b1;
              end else if (b inside {[8'h41:8'h5A], [8'h61:8'h7A]}) begin
                // low five bits run from 1 for a/A up to 26 for z/Z
                letters_nxt[5'(b[4:0] - 5'd1)] = 1'b1;
              end else if (b inside {[8'h30:8'h39]}) begin
                digits_nxt[b[3:0]] = 1'b1;
              end else if (b == tak_pkg::B_CR) begin
                others_nxt[tak_pkg::K_ENTER] = 1'b1;
              end else if (b == tak_pkg::B_ESC) begin
                phase_nxt = tak_pkg::PH_ESC;
              end else if (b == tak_pkg::B_IAC) begin
                phase_nxt = tak_pkg::PH_IAC;
              end
            end
          endcase
        end
      end

      // end of buffer drops any partial sequence, a pending escape counts as esc
      if (in_ch.last_of_buffer) begin
        if (phase_nxt == tak_pkg::PH_ESC || phase_nxt == tak_pkg::PH_ESC_BR) begin
          others_nxt[tak_pkg::K_ESC] = 1'b1;
        end
        phase_nxt    = tak_pkg::PH_IDLE;
        size_cnt_nxt = '0;
      end
    end
  end

  // clamp of the reported size
  assign cols_raw = size_sh_nxt[31:16];
  assign rows_raw = size_sh_nxt[15:0];
  assign cols_cl  = (cols_raw < min_cols_r) ? min_cols_r :
                    (cols_raw > max_cols_r) ? max_cols_r : cols_raw;
  assign rows_cl  = (rows_raw < min_rows_r) ? min_rows_r :
                    (rows_raw > max_rows_r) ? max_rows_r : rows_raw;

  // result assembly
  always_comb begin
    out_nxt.letter_keys         = letters_nxt;
    out_nxt.digit_keys          = digits_nxt;
    out_nxt.other_keys          = others_nxt;
    out_nxt.window_size_enabled = naws_on_nxt;
    out_nxt.resize_valid        = resized;
    out_nxt.width_cols          = resized ? cols_cl : 16'd0;
    out_nxt.height_rows         = resized ? rows_cl : 16'd0;
  end

  // state and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= tak_pkg::PH_IDLE;
      neg_will_r  <= 1'b0;
      size_sh_r   <= '0;
      size_cnt_r  <= '0;
      letters_r   <= '0;
      digits_r    <= '0;
      others_r    <= '0;
      naws_on_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r    <= phase_nxt;
        neg_will_r <= neg_will_nxt;
        size_sh_r  <= size_sh_nxt;
        size_cnt_r <= size_cnt_nxt;
        letters_r  <= letters_nxt;
        digits_r   <= digits_nxt;
        others_r   <= others_nxt;
        naws_on_r  <= naws_on_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) out_r <= out_nxt;
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.letter_keys         = out_r.letter_keys;
  assign out_ch.digit_keys          = out_r.digit_keys;
  assign out_ch.other_keys          = out_r.other_keys;
  assign out_ch.window_size_enabled = out_r.window_size_enabled;
  assign out_ch.resize_valid        = out_r.resize_valid;
  assign out_ch.width_cols          = out_r.width_cols;
  assign out_ch.height_rows         = out_r.height_rows;

endmodule

### test/telnet_ansi_key_input_decoder_top_test.sv
// testbench for the telnet key input decoder: directed and random byte streams, checked per result
`timescale 1ns / 100ps

module telnet_ansi_key_input_decoder_top_test;

  // printable byte values and the case fold mask used in the prediction
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CASE_FOLD  = 8'hDF;

  localparam int CYCLE_LIMIT = 300000;
  localparam int LONG_HOLD   = 64;

  typedef logic [7:0] byte_q_t[$];

  typedef enum int {
    NAWS_CLEAN,
    NAWS_UNDOUBLED,
    NAWS_NO_SE,
    NAWS_BAD_SE,
    NAWS_CUT
  } naws_variant_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  tak_in_if  in_ch ();
  tak_out_if out_ch ();

  telnet_ansi_key_input_decoder_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // decoder state as predicted
  logic [3:0]  dec_phase;
  logic        dec_will;
  logic [31:0] dec_size_shift;
  logic [2:0]  dec_size_count;
  logic [25:0] dec_letters;
  logic [9:0]  dec_digits;
  logic [6:0]  dec_others;
  logic        dec_naws;
  logic [15:0] bound_min_cols;
  logic [15:0] bound_max_cols;
  logic [15:0] bound_min_rows;
  logic [15:0] bound_max_rows;

  tak_pkg::out_item_t pending_results[$];
  int        items_sent;
  int        error_count;
  int        cycle_count;
  int        hold_cycles;
  bit        in_gaps_on;
  bit        out_stalls_on;
  bit        idle_allowed;

  function automatic void reset_decoder_state();
    dec_phase      = tak_pkg::PH_IDLE;
    dec_will       = 1'b0;
    dec_size_shift = '0;
    dec_size_count = '0;
    dec_letters    = '0;
    dec_digits     = '0;
    dec_others     = '0;
    dec_naws       = 1'b0;
    bound_min_cols = tak_pkg::RST_MIN_COLS;
    bound_max_cols = tak_pkg::RST_MAX_COLS;
    bound_min_rows = tak_pkg::RST_MIN_ROWS;
    bound_max_rows = tak_pkg::RST_MAX_ROWS;
  endfunction

  function automatic void take_size_byte(input logic [7:0] b);
    dec_size_shift = {dec_size_shift[23:0], b};
    dec_size_count = dec_size_count + 3'd1;
    dec_phase = (dec_size_count >= tak_pkg::NAWS_BYTES) ? tak_pkg::PH_NAWS_END :
                tak_pkg::PH_NAWS_DATA;
  endfunction

  function automatic logic [15:0] clamp_size(input logic [15:0] v, input logic [15:0] lo,
                                             input logic [15:0] hi);
    logic [15:0] r;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  // one byte through the parser; some phases hand the byte on to the next phase
  function automatic bit decode_byte(input logic [7:0] b);
    bit again;
    bit resized;
    resized = 1'b0;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (dec_phase)
        tak_pkg::PH_ESC: begin
          if (b == tak_pkg::B_BRACK) dec_phase = tak_pkg::PH_ESC_BR;
          else begin
            dec_others[tak_pkg::K_ESC] = 1'b1;
            dec_phase = tak_pkg::PH_IDLE;
            again = 1'b1;
          end
        end
        tak_pkg::PH_ESC_BR: begin
          dec_phase = tak_pkg::PH_IDLE;
          if (b == tak_pkg::B_UP) dec_others[tak_pkg::K_UP] = 1'b1;
          else if (b == tak_pkg::B_DOWN) dec_others[tak_pkg::K_DOWN] = 1'b1;
          else if (b == tak_pkg::B_RIGHT) dec_others[tak_pkg::K_RIGHT] = 1'b1;
          else if (b == tak_pkg::B_LEFT) dec_others[tak_pkg::K_LEFT] = 1'b1;
          else begin
            dec_others[tak_pkg::K_ESC] = 1'b1;
            again = 1'b1;
          end
        end
        tak_pkg::PH_IAC: begin
          if (b == tak_pkg::B_IAC) dec_phase = tak_pkg::PH_IDLE;
          else if (b == tak_pkg::B_WILL || b == tak_pkg::B_WONT ||
                   b == tak_pkg::B_DO || b == tak_pkg::B_DONT) begin
            dec_will = (b == tak_pkg::B_WILL);
            dec_phase = tak_pkg::PH_NEG;
          end else if (b == tak_pkg::B_SB) dec_phase = tak_pkg::PH_SB;
          else begin
            dec_phase = tak_pkg::PH_IDLE;
            again = 1'b1;
          end
        end
        tak_pkg::PH_NEG: begin
          if (b == tak_pkg::OPT_NAWS) dec_naws = dec_will;
          dec_phase = tak_pkg::PH_IDLE;
        end
        tak_pkg::PH_SB: begin
          if (b == tak_pkg::OPT_NAWS) begin
            dec_size_shift = '0;
            dec_size_count = '0;
            dec_phase = tak_pkg::PH_NAWS_DATA;
          end else dec_phase = tak_pkg::PH_SKIP;
        end
        tak_pkg::PH_NAWS_DATA: begin
          if (b == tak_pkg::B_IAC) dec_phase = tak_pkg::PH_NAWS_FF;
          else take_size_byte(b);
        end
        tak_pkg::PH_NAWS_FF: begin
          if (b == tak_pkg::B_IAC) take_size_byte(b);
          else begin
            dec_phase = tak_pkg::PH_IAC;
            again = 1'b1;
          end
        end
        tak_pkg::PH_NAWS_END: begin
          if (b == tak_pkg::B_IAC) dec_phase = tak_pkg::PH_NAWS_END_IAC;
          else begin
            dec_phase = tak_pkg::PH_IDLE;
            again = 1'b1;
          end
        end
        tak_pkg::PH_NAWS_END_IAC: begin
          if (b == tak_pkg::B_SE) begin
            dec_phase = tak_pkg::PH_IDLE;
            resized = 1'b1;
          end else begin
            dec_phase = tak_pkg::PH_IAC;
            again = 1'b1;
          end
        end
        tak_pkg::PH_SKIP: begin
          if (b == tak_pkg::B_IAC) dec_phase = tak_pkg::PH_SKIP_IAC;
        end
        tak_pkg::PH_SKIP_IAC: begin
          dec_phase = (b == tak_pkg::B_SE) ? tak_pkg::PH_IDLE : tak_pkg::PH_SKIP;
        end
        default: begin
          dec_phase = tak_pkg::PH_IDLE;
          if (b == tak_pkg::B_SPACE) dec_others[tak_pkg::K_SPACE] = 1'b1;
          else if ((b >= CH_LOWER_A && b <= CH_LOWER_Z) || (b >= CH_UPPER_A && b <= CH_UPPER_Z))
            dec_letters[5'((b & CASE_FOLD) - CH_UPPER_A)] = 1'b1;
          else if (b >= CH_ZERO && b <= CH_NINE) dec_digits[4'(b - CH_ZERO)] = 1'b1;
          else if (b == tak_pkg::B_CR) dec_others[tak_pkg::K_ENTER] = 1'b1;
          else if (b == tak_pkg::B_ESC) dec_phase = tak_pkg::PH_ESC;
          else if (b == tak_pkg::B_IAC) dec_phase = tak_pkg::PH_IAC;
        end
      endcase
    end
    return resized;
  endfunction

  // expected result of one accepted input transfer
  function automatic tak_pkg::out_item_t decoder_step(input tak_pkg::in_item_t it);
    tak_pkg::out_item_t r;
    bit resized;
    r = '0;
    resized = 1'b0;
    if (it.command) begin
      dec_letters = '0;
      dec_digits  = '0;
      dec_others  = '0;
    end else begin
      resized = decode_byte(it.data_byte);
      if (resized) begin
        r.width_cols  = clamp_size(dec_size_shift[31:16], bound_min_cols, bound_max_cols);
        r.height_rows = clamp_size(dec_size_shift[15:0], bound_min_rows, bound_max_rows);
      end
      // end of buffer drops any partial sequence, a pending escape counts as esc
      if (it.last_of_buffer) begin
        if (dec_phase == tak_pkg::PH_ESC || dec_phase == tak_pkg::PH_ESC_BR)
          dec_others[tak_pkg::K_ESC] = 1'b1;
        dec_phase = tak_pkg::PH_IDLE;
        dec_size_count = '0;
      end
    end
    r.letter_keys         = dec_letters;
    r.digit_keys          = dec_digits;
    r.other_keys          = dec_others;
    r.window_size_enabled = dec_naws;
    r.resize_valid        = resized;
    return r;
  endfunction

  // one input transfer; valid stays high unless a gap follows
  task automatic send_item(input logic cmd, input logic [7:0] b, input logic last);
    tak_pkg::in_item_t it;
    it.command        = cmd;
    it.data_byte      = b;
    it.last_of_buffer = last;
    in_ch.valid          <= 1'b1;
    in_ch.command        <= cmd;
    in_ch.data_byte      <= b;
    in_ch.last_of_buffer <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(decoder_step(it));
    items_sent++;
    if (in_gaps_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic send_seq(input byte_q_t seq, input bit end_last, input bit spray_last);
    foreach (seq[i])
      send_item(1'b0, seq[i], (i == seq.size() - 1) ? end_last :
                (spray_last && $urandom_range(0, 39) == 0));
  endtask

  // window size subnegotiation, well formed or broken in one of several ways
  task automatic send_naws(input logic [15:0] cols, input logic [15:0] rows,
                           input naws_variant_t variant, input bit spray_last);
    logic [7:0] size_bytes[4];
    logic [7:0] b;
    byte_q_t    seq;
    bit         undoubled_done;
    int         cut_at;
    size_bytes = '{cols[15:8], cols[7:0], rows[15:8], rows[7:0]};
    if (variant == NAWS_UNDOUBLED) size_bytes[$urandom_range(0, 3)] = tak_pkg::B_IAC;
    seq = '{tak_pkg::B_IAC, tak_pkg::B_SB, tak_pkg::OPT_NAWS};
    undoubled_done = 1'b0;
    foreach (size_bytes[i]) begin
      seq.push_back(size_bytes[i]);
      if (size_bytes[i] == tak_pkg::B_IAC) begin
        if (variant == NAWS_UNDOUBLED && !undoubled_done) undoubled_done = 1'b1;
        else seq.push_back(tak_pkg::B_IAC);
      end
    end
    case (variant)
      NAWS_NO_SE: begin
        seq.push_back(8'($urandom_range(0, 254)));
      end
      NAWS_BAD_SE: begin
        do b = 8'($urandom); while (b == tak_pkg::B_SE);
        seq.push_back(tak_pkg::B_IAC);
        seq.push_back(b);
      end
      default: begin
        seq.push_back(tak_pkg::B_IAC);
        seq.push_back(tak_pkg::B_SE);
      end
    endcase
    if (variant == NAWS_CUT) begin
      cut_at = $urandom_range(1, seq.size() - 1);
      while (seq.size() > cut_at) void'(seq.pop_back());
    end
    send_seq(seq, variant == NAWS_CUT || $urandom_range(0, 5) == 0, spray_last);
  endtask

  // size value biased towards the clamp bounds and the byte extremes
  function automatic logic [15:0] pick_size(input logic [15:0] lo, input logic [15:0] hi);
    logic [15:0] v;
    case ($urandom_range(0, 7))
      0: v = 16'h0000;
      1: v = 16'hFFFF;
      2: v = lo;
      3: v = hi;
      4: v = lo - 16'd1;
      5: v = hi + 16'd1;
      6: v = {8'hFF, 8'($urandom)};
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // apb write; psel stays high so back-to-back writes need no idle phase between them
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {16'h0000, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      tak_pkg::REG_MIN_COLS: bound_min_cols = val;
      tak_pkg::REG_MAX_COLS: bound_max_cols = val;
      tak_pkg::REG_MIN_ROWS: bound_min_rows = val;
      default:               bound_max_rows = val;
    endcase
  endtask

  task automatic set_bounds(input logic [15:0] min_c, input logic [15:0] max_c,
                            input logic [15:0] min_r, input logic [15:0] max_r);
    wait_drained();
    write_reg(tak_pkg::REG_MIN_COLS, min_c);
    write_reg(tak_pkg::REG_MAX_COLS, max_c);
    write_reg(tak_pkg::REG_MIN_ROWS, min_r);
    write_reg(tak_pkg::REG_MAX_ROWS, max_r);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // mostly well formed sequences with random content, some noise and broken ones
  task automatic random_traffic(input int count);
    int         target;
    int         pick;
    int         n;
    logic [7:0] opt;
    logic [7:0] b;
    byte_q_t    seq;
    naws_variant_t variant;
    target = items_sent + count;
    while (items_sent < target) begin
      if (idle_allowed && $urandom_range(0, 47) == 0) in_gaps_on = !in_gaps_on;
      if (idle_allowed && $urandom_range(0, 47) == 0) out_stalls_on = !out_stalls_on;
      seq.delete();
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        case ($urandom_range(0, 3))
          0: b = CH_UPPER_A + 8'($urandom_range(0, 25));
          1: b = CH_LOWER_A + 8'($urandom_range(0, 25));
          2: b = CH_ZERO + 8'($urandom_range(0, 9));
          default: b = $urandom_range(0, 1) ? tak_pkg::B_SPACE : tak_pkg::B_CR;
        endcase
        seq.push_back(b);
      end else if (pick < 42) begin
        seq = '{tak_pkg::B_ESC, tak_pkg::B_BRACK, tak_pkg::B_UP + 8'($urandom_range(0, 3))};
      end else if (pick < 48) begin
        // unhandled escape, with or without the bracket
        seq.push_back(tak_pkg::B_ESC);
        if ($urandom_range(0, 1)) seq.push_back(tak_pkg::B_BRACK);
        seq.push_back(8'($urandom));
      end else if (pick < 58) begin
        opt = $urandom_range(0, 1) ? tak_pkg::OPT_NAWS : 8'($urandom);
        seq = '{tak_pkg::B_IAC, tak_pkg::B_WILL + 8'($urandom_range(0, 3)), opt};
      end else if (pick < 61) begin
        seq = '{tak_pkg::B_IAC, tak_pkg::B_IAC};
      end else if (pick < 65) begin
        seq = '{tak_pkg::B_IAC, 8'($urandom)};
      end else if (pick < 83) begin
        case ($urandom_range(0, 9))
          6: variant = NAWS_UNDOUBLED;
          7: variant = NAWS_NO_SE;
          8: variant = NAWS_BAD_SE;
          9: variant = NAWS_CUT;
          default: variant = NAWS_CLEAN;
        endcase
        send_naws(pick_size(bound_min_cols, bound_max_cols),
                  pick_size(bound_min_rows, bound_max_rows), variant, 1'b1);
      end else if (pick < 89) begin
        // other subnegotiation, skipped up to iac se
        do opt = 8'($urandom); while (opt == tak_pkg::OPT_NAWS);
        seq = '{tak_pkg::B_IAC, tak_pkg::B_SB, opt};
        n = $urandom_range(0, 6);
        repeat (n) begin
          if ($urandom_range(0, 4) == 0) begin
            seq.push_back(tak_pkg::B_IAC);
            seq.push_back(tak_pkg::B_IAC);
          end else seq.push_back(8'($urandom_range(0, 254)));
        end
        seq.push_back(tak_pkg::B_IAC);
        seq.push_back(tak_pkg::B_SE);
      end else if (pick < 93) begin
        send_item(1'b1, 8'($urandom), 1'($urandom));
      end else begin
        seq.push_back(8'($urandom));
      end
      if (seq.size() != 0) send_seq(seq, $urandom_range(0, 5) == 0, 1'b1);
    end
  endtask

  task automatic test_keys();
    byte_q_t seq;
    seq = '{CH_UPPER_A, CH_LOWER_Z, CH_ZERO, CH_NINE, tak_pkg::B_SPACE, tak_pkg::B_CR};
    send_seq(seq, 1'b0, 1'b0);
    // clear with the other fields set, they must be ignored
    send_item(1'b1, tak_pkg::B_ESC, 1'b1);
    seq = '{tak_pkg::B_ESC, tak_pkg::B_BRACK, tak_pkg::B_LEFT, tak_pkg::B_ESC, 8'h80};
    send_seq(seq, 1'b0, 1'b0);
    // escape pending at end of buffer
    seq = '{tak_pkg::B_ESC, tak_pkg::B_BRACK};
    send_seq(seq, 1'b1, 1'b0);
  endtask

  task automatic test_telnet();
    byte_q_t seq;
    seq = '{tak_pkg::B_IAC, tak_pkg::B_IAC, tak_pkg::B_IAC, CH_UPPER_Z, tak_pkg::B_IAC,
            tak_pkg::B_WILL, tak_pkg::OPT_NAWS};
    send_seq(seq, 1'b0, 1'b0);
    // both sizes out of the reset bounds, doubled 0xff bytes
    send_naws(16'hFFFF, 16'h0000, NAWS_CLEAN, 1'b0);
    seq = '{tak_pkg::B_IAC, tak_pkg::B_DONT, tak_pkg::OPT_NAWS};
    send_seq(seq, 1'b0, 1'b0);
    wait_drained();
  endtask

  task automatic test_random_reset_bounds();
    in_gaps_on = 1'b1;
    out_stalls_on = 1'b1;
    random_traffic(200);
  endtask

  task automatic test_bound_extremes();
    set_bounds(16'd1, 16'd65535, 16'd1, 16'd65535);
    random_traffic(300);
    set_bounds(16'd65535, 16'd65535, 16'd1, 16'd1);
    random_traffic(300);
    // minimum above maximum
    set_bounds(16'd300, 16'd100, 16'd50, 16'd10);
    random_traffic(300);
  endtask

  task automatic test_bounds_random();
    repeat (3) begin
      set_bounds(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                 16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
      random_traffic(150);
    end
  endtask

  // long receiver hold while the sender keeps offering, then a full pause
  task automatic test_backpressure();
    in_gaps_on = 1'b0;
    hold_cycles = LONG_HOLD;
    random_traffic(40);
    wait_drained();
    in_gaps_on = 1'b1;
  endtask

  task automatic test_no_idle();
    set_bounds(16'd20, 16'd100, 16'd10, 16'd60);
    idle_allowed = 1'b0;
    in_gaps_on = 1'b0;
    out_stalls_on = 1'b0;
    random_traffic(300);
  endtask

  // result checking
  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    tak_pkg::out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result transfer with none expected, expected none, actual %h", $time,
                 {out_ch.letter_keys, out_ch.digit_keys, out_ch.other_keys});
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("letter_keys", want.letter_keys, out_ch.letter_keys);
        check_field("digit_keys", want.digit_keys, out_ch.digit_keys);
        check_field("other_keys", want.other_keys, out_ch.other_keys);
        check_field("window_size_enabled", want.window_size_enabled,
                    out_ch.window_size_enabled);
        check_field("resize_valid", want.resize_valid, out_ch.resize_valid);
        check_field("width_cols", want.width_cols, out_ch.width_cols);
        check_field("height_rows", want.height_rows, out_ch.height_rows);
      end
    end
  end

  // result ready: long hold on request, random stall bursts, else ready
  initial begin : drive_result_ready
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else if (out_stalls_on && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("telnet_ansi_key_input_decoder_top_test: errors");
      $finish;
    end
  end

  initial begin
    items_sent    = 0;
    error_count   = 0;
    cycle_count   = 0;
    hold_cycles   = 0;
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    idle_allowed  = 1'b1;
    reset_decoder_state();
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.command        <= 1'b0;
    in_ch.data_byte      <= '0;
    in_ch.last_of_buffer <= 1'b0;
    cfg_psel             <= 1'b0;
    cfg_penable          <= 1'b0;
    cfg_pwrite           <= 1'b0;
    cfg_paddr            <= '0;
    cfg_pwdata           <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_keys();
    test_telnet();
    test_random_reset_bounds();
    test_bound_extremes();
    test_backpressure();
    test_bounds_random();
    test_no_idle();

    wait_drained();
    if (error_count == 0)
      $display("telnet_ansi_key_input_decoder_top_test: clean");
    else
      $display("telnet_ansi_key_input_decoder_top_test: errors");
    $finish;
  end

endmodule
